### sv/vprb_pkg.sv
package vprb_pkg;

    // Input action codes
    localparam logic [2:0] ACT_PUT_HEADER = 3'd0;
    localparam logic [2:0] ACT_PUT_WORD   = 3'd1;
    localparam logic [2:0] ACT_PEEK       = 3'd2;
    localparam logic [2:0] ACT_READ_WORD  = 3'd3;
    localparam logic [2:0] ACT_RELEASE    = 3'd4;

    // Result status codes
    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_FULL    = 3'd1,
        ST_LONG    = 3'd2,
        ST_EMPTY   = 3'd3,
        ST_OVERRUN = 3'd4
    } t_status;

    // Controller states, one-hot
    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } t_state;

    // Commands from controller to datapath
    typedef struct packed {
        logic capture;  // transaction accepted: latch fields, issue store read
        logic commit;   // apply the action and load the output register
    } t_cmd;

    // Packet size in words fits 8 bits: 1 + 31 + 64 at most
    localparam int TOT_W = 8;
    typedef logic [TOT_W-1:0] t_total;

    // Header word layout
    localparam int SPILL_POS = 31;
    localparam int IN_TDATA_W  = 48;  // byte_len, data_word, word_offset, pad
    localparam int OUT_TDATA_W = 40;  // head_len, read_data

    // 1 + frame + data length rounded up to whole words
    function automatic t_total packet_words(input logic [7:0] len, input logic [4:0] frame);
        logic [8:0] padded;
        padded = {1'b0, len} + 9'd3;
        return TOT_W'(1) + TOT_W'(frame) + TOT_W'(padded >> 2);
    endfunction

endpackage

### sv/vprb_ctrl.sv
module vprb_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output vprb_pkg::t_cmd    o_cmd
);

    vprb_pkg::t_state r_state, n_state;
    logic             r_out_valid, n_out_valid;
    logic             accept;
    logic             out_free;

    assign s_axis_tready = (r_state == vprb_pkg::S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign accept        = s_axis_tvalid & s_axis_tready;
    assign out_free      = !r_out_valid || m_axis_tready;

    always_comb begin
        n_state       = r_state;
        o_cmd.capture = 1'b0;
        o_cmd.commit  = 1'b0;
        case (r_state)
            vprb_pkg::S_IDLE: begin
                if (accept) begin
                    o_cmd.capture = 1'b1;
                    n_state       = vprb_pkg::S_EXEC;
                end
            end
            vprb_pkg::S_EXEC: begin
                // hold here while the previous result is still unclaimed
                if (out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = vprb_pkg::S_IDLE;
                end
            end
            default: n_state = vprb_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        if (o_cmd.commit) begin
            n_out_valid = 1'b1;
        end else if (m_axis_tready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= vprb_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    a_accept_to_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == vprb_pkg::S_EXEC) && !s_axis_tready)
        else $error("accepted transaction did not move to execute");

    a_commit_shows_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.commit |=> m_axis_tvalid)
        else $error("committed result not presented");

    a_stall_holds_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == vprb_pkg::S_EXEC) && r_out_valid && !m_axis_tready
        |=> (r_state == vprb_pkg::S_EXEC) && $stable(r_out_valid))
        else $error("result overwritten while receiver stalls");

endmodule

### sv/vprb_dp.sv
module vprb_dp #(
    parameter int BUF_WORDS        = 1024,
    parameter int MAX_PACKET_WORDS = 64,
    parameter int FRAME_WORDS      = 4
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  vprb_pkg::t_cmd                     i_cmd,
    input  logic [vprb_pkg::IN_TDATA_W-1:0]    i_tdata,
    input  logic [2:0]                         i_tuser,
    output logic [vprb_pkg::OUT_TDATA_W-1:0]   o_tdata,
    output logic [2:0]                         o_tuser
);

    localparam int DEPTH = BUF_WORDS + MAX_PACKET_WORDS;
    localparam int AW    = $clog2(DEPTH);
    localparam int PW    = $clog2(BUF_WORDS);
    localparam int CW    = PW + 1;
    localparam int FW    = $clog2(DEPTH + 1);
    localparam int RW    = $clog2(MAX_PACKET_WORDS + 1);

    // packet store: one write and one registered read port
    logic [31:0]   mem [DEPTH];
    logic [31:0]   r_rdata;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [31:0]   wr_data;
    logic [AW-1:0] rd_addr;

    logic [CW-1:0] r_wcnt, n_wcnt;
    logic [CW-1:0] r_rcnt, n_rcnt;
    logic [FW-1:0] r_fill_addr, n_fill_addr;
    logic [RW-1:0] r_fill_rem, n_fill_rem;

    logic [2:0]    r_action;
    logic [7:0]    r_len;
    logic [31:0]   r_word;

    vprb_pkg::t_status r_status, n_status;
    logic [7:0]        r_head_len, n_head_len;
    logic [31:0]       r_read_data, n_read_data;

    logic [7:0]      in_len;
    logic [31:0]     in_word;
    logic [5:0]      in_offs;
    logic [AW:0]     rd_sum;
    logic [PW-1:0]   pos_w;
    logic [PW-1:0]   pos_r;
    logic [CW-1:0]   used;
    vprb_pkg::t_total total;
    vprb_pkg::t_total head_total;
    logic            too_long;
    logic            full;
    logic            spill;
    logic            overrun;

    assign in_len  = i_tdata[7:0];
    assign in_word = i_tdata[39:8];
    assign in_offs = i_tdata[45:40];

    assign pos_w = r_wcnt[PW-1:0];
    assign pos_r = r_rcnt[PW-1:0];
    assign used  = r_wcnt - r_rcnt;

    // read address: head header, or the addressed word wrapped at the store depth
    assign rd_sum = (AW+1)'(pos_r) + (AW+1)'(1) + (AW+1)'(in_offs);
    always_comb begin
        if (i_tuser == vprb_pkg::ACT_READ_WORD) begin
            rd_addr = (rd_sum >= (AW+1)'(DEPTH)) ? AW'(rd_sum - (AW+1)'(DEPTH)) : AW'(rd_sum);
        end else begin
            rd_addr = AW'(pos_r);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_rdata  <= mem[rd_addr];
            r_action <= i_tuser;
            r_len    <= in_len;
            r_word   <= in_word;
        end
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    assign total      = vprb_pkg::packet_words(r_len, 5'(FRAME_WORDS));
    assign head_total = vprb_pkg::packet_words(r_rdata[7:0], 5'(FRAME_WORDS));
    assign too_long   = total > vprb_pkg::TOT_W'(MAX_PACKET_WORDS);
    assign full       = ((CW+1)'(used) + (CW+1)'(total)) > (CW+1)'(BUF_WORDS);
    assign spill      = ((CW+1)'(pos_w) + (CW+1)'(total)) > (CW+1)'(BUF_WORDS);
    assign overrun    = (r_fill_rem == '0) || (r_fill_addr >= FW'(DEPTH));

    always_comb begin
        n_wcnt      = r_wcnt;
        n_rcnt      = r_rcnt;
        n_fill_addr = r_fill_addr;
        n_fill_rem  = r_fill_rem;
        n_status    = vprb_pkg::ST_OK;
        n_head_len  = '0;
        n_read_data = '0;
        wr_en       = 1'b0;
        wr_addr     = AW'(pos_w);
        wr_data     = {spill, 23'd0, r_len};
        case (r_action)
            vprb_pkg::ACT_PUT_HEADER: begin
                if (too_long) begin
                    n_status = vprb_pkg::ST_LONG;
                end else if (full) begin
                    n_status = vprb_pkg::ST_FULL;
                end else begin
                    wr_en = i_cmd.commit;
                    // a spilled packet runs into the overflow area; skip to ring start
                    if (spill) begin
                        n_wcnt = r_wcnt + (CW'(BUF_WORDS) - CW'(pos_w));
                    end else begin
                        n_wcnt = r_wcnt + CW'(total);
                    end
                    n_fill_addr = FW'(pos_w) + FW'(1);
                    n_fill_rem  = RW'(total - vprb_pkg::TOT_W'(1));
                end
            end
            vprb_pkg::ACT_PUT_WORD: begin
                wr_addr = r_fill_addr[AW-1:0];
                wr_data = r_word;
                if (overrun) begin
                    n_status = vprb_pkg::ST_OVERRUN;
                end else begin
                    wr_en       = i_cmd.commit;
                    n_fill_addr = r_fill_addr + FW'(1);
                    n_fill_rem  = r_fill_rem - RW'(1);
                end
            end
            vprb_pkg::ACT_PEEK, vprb_pkg::ACT_READ_WORD, vprb_pkg::ACT_RELEASE: begin
                if (used == '0) begin
                    n_status = vprb_pkg::ST_EMPTY;
                end else if (r_action == vprb_pkg::ACT_PEEK) begin
                    n_head_len = r_rdata[7:0];
                end else if (r_action == vprb_pkg::ACT_READ_WORD) begin
                    n_read_data = r_rdata;
                end else if (r_rdata[vprb_pkg::SPILL_POS]) begin
                    n_rcnt = r_rcnt + (CW'(BUF_WORDS) - CW'(pos_r));
                end else begin
                    n_rcnt = r_rcnt + CW'(head_total);
                end
            end
            default: begin
                n_status = vprb_pkg::ST_OK;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wcnt      <= '0;
            r_rcnt      <= '0;
            r_fill_addr <= '0;
            r_fill_rem  <= '0;
        end else if (i_cmd.commit) begin
            r_wcnt      <= n_wcnt;
            r_rcnt      <= n_rcnt;
            r_fill_addr <= n_fill_addr;
            r_fill_rem  <= n_fill_rem;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_status    <= n_status;
            r_head_len  <= n_head_len;
            r_read_data <= n_read_data;
        end
    end

    assign o_tdata = {r_read_data, r_head_len};
    assign o_tuser = r_status;

    a_used_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (CW+1)'(used) <= (CW+1)'(BUF_WORDS))
        else $error("ring occupancy exceeds buffer size");

    a_slot_in_store: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fill_rem != '0) |-> ((FW+1)'(r_fill_addr) + (FW+1)'(r_fill_rem) <= (FW+1)'(DEPTH)))
        else $error("reserved slot runs past the store");

endmodule

### sv/variable_packet_ring_buffer_unit.sv
// Variable-length packet ring buffer.
// Input channel s_axis carries one command per transaction: tuser holds the
// action (put_header, put_word, peek, read_word, release) and tdata holds
// byte_len, data_word and word_offset. Output channel m_axis returns exactly
// one result per command: tuser holds the status, tdata holds head_len and
// read_data (zero unless a peek or read_word succeeded).
// Packets live in a word store of BUF_WORDS ring words plus MAX_PACKET_WORDS
// overflow words: a header word, FRAME_WORDS frame words, then the data.
// Commands are taken one at a time: a new one is accepted only once the last has
// executed. The accept cycle issues the store read of the head header (or the
// addressed word); the execute state then, once the output register is free,
// applies the action, writes the store and loads the output register.
// When the receiver stalls, the finished result waits in the output register;
// the next command is still taken and is held in its execute cycle until the
// waiting result leaves. At reset the counters and fill slot clear, so the
// ring is empty; store contents are undefined until written, and no clearing
// pass runs.
module variable_packet_ring_buffer_unit #(
    parameter int BUF_WORDS        = 1024,
    parameter int MAX_PACKET_WORDS = 64,
    parameter int FRAME_WORDS      = 4
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // byte_len [7:0], data_word [39:8], word_offset [45:40], zero pad [47:46]
    input  logic [vprb_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    // action [2:0]
    input  logic [2:0]                       s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // head_len [7:0], read_data [39:8]
    output logic [vprb_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    // status [2:0]
    output logic [2:0]                       m_axis_tuser
);

    vprb_pkg::t_cmd cmd;

    // Sequence each transaction: capture, then execute once the output is free
    vprb_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .o_cmd         (cmd)
    );

    // Store, ring counters, fill slot and result register
    vprb_dp #(
        .BUF_WORDS        (BUF_WORDS),
        .MAX_PACKET_WORDS (MAX_PACKET_WORDS),
        .FRAME_WORDS      (FRAME_WORDS)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .i_tdata (s_axis_tdata),
        .i_tuser (s_axis_tuser),
        .o_tdata (m_axis_tdata),
        .o_tuser (m_axis_tuser)
    );

endmodule

### verif/vprb_ring_checker.sv
module vprb_ring_checker
    import vprb_pkg::*;
#(
    parameter int BUF_WORDS        = 1024,
    parameter int MAX_PACKET_WORDS = 64,
    parameter int FRAME_WORDS      = 4
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_cmd_valid,
    input  logic                                    i_cmd_ready,
    // byte_len [7:0], data_word [39:8], word_offset [45:40], zero pad [47:46]
    input  logic [IN_TDATA_W-1:0]                   i_cmd_data,
    // action [2:0]
    input  logic [2:0]                              i_cmd_user,
    input  logic                                    i_res_valid,
    input  logic                                    i_res_ready,
    // head_len [7:0], read_data [39:8]
    input  logic [OUT_TDATA_W-1:0]                  i_res_data,
    // status [2:0]
    input  logic [2:0]                              i_res_user,
    output int                                      o_mismatches,
    output int                                      o_outstanding,
    output logic                                    o_ring_empty,
    output int                                      o_head_pos,
    output logic [BUF_WORDS+MAX_PACKET_WORDS-1:0]   o_written
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STORE_DEPTH = BUF_WORDS + MAX_PACKET_WORDS;
    localparam int CNT_W       = $clog2(2 * BUF_WORDS);
    localparam int POS_W       = $clog2(BUF_WORDS);
    localparam logic [31:0] SPILL_MARK = 32'(1) << SPILL_POS;

    typedef struct packed {
        t_status     status;
        logic [7:0]  head_len;
        logic [31:0] read_data;
    } ring_response_t;

    logic [31:0]            shadow_store [STORE_DEPTH];
    logic [STORE_DEPTH-1:0] written = '0;
    logic [CNT_W-1:0]       wr_count = '0;
    logic [CNT_W-1:0]       rd_count = '0;
    int unsigned            fill_addr = 0;
    int unsigned            fill_left = 0;
    ring_response_t         pending_responses [$];
    int                     mismatches = 0;
    int                     outstanding = 0;

    assign o_mismatches  = mismatches;
    assign o_outstanding = outstanding;
    assign o_ring_empty  = (wr_count == rd_count);
    assign o_head_pos    = int'(rd_count[POS_W-1:0]);
    assign o_written     = written;

    function automatic int unsigned slot_words(input logic [7:0] len);
        return 1 + FRAME_WORDS + (int'(len) + 3) / 4;
    endfunction

    // Apply one command to the shadow ring and return the response it earns.
    function automatic ring_response_t ring_response(input logic [2:0] act,
                                                     input logic [7:0] len,
                                                     input logic [31:0] word,
                                                     input logic [5:0] offs);
        ring_response_t   r;
        logic [CNT_W-1:0] diff;
        int unsigned      used;
        int unsigned      total;
        int unsigned      pos;
        int unsigned      idx;
        logic [31:0]      hdr;
        r.status    = ST_OK;
        r.head_len  = '0;
        r.read_data = '0;
        diff = wr_count - rd_count;
        used = diff;
        case (act)
            ACT_PUT_HEADER: begin
                total = slot_words(len);
                if (total > MAX_PACKET_WORDS) begin
                    r.status = ST_LONG;
                end else if (total + used > BUF_WORDS) begin
                    r.status = ST_FULL;
                end else begin
                    pos = wr_count[POS_W-1:0];
                    // A packet that would cross the ring end lands whole in the
                    // overflow area; skip the write count to the next lap.
                    if (pos + total > BUF_WORDS) begin
                        shadow_store[pos] = SPILL_MARK | 32'(len);
                        wr_count = wr_count + CNT_W'(BUF_WORDS - pos);
                    end else begin
                        shadow_store[pos] = 32'(len);
                        wr_count = wr_count + CNT_W'(total);
                    end
                    written[pos] = 1'b1;
                    fill_addr = pos + 1;
                    fill_left = total - 1;
                end
            end
            ACT_PUT_WORD: begin
                if (fill_left == 0 || fill_addr >= STORE_DEPTH) begin
                    r.status = ST_OVERRUN;
                end else begin
                    shadow_store[fill_addr] = word;
                    written[fill_addr] = 1'b1;
                    fill_addr++;
                    fill_left--;
                end
            end
            ACT_PEEK, ACT_READ_WORD, ACT_RELEASE: begin
                if (used == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    pos = rd_count[POS_W-1:0];
                    hdr = shadow_store[pos];
                    if (act == ACT_PEEK) begin
                        r.head_len = hdr[7:0];
                    end else if (act == ACT_READ_WORD) begin
                        idx = (pos + 1 + offs) % STORE_DEPTH;
                        r.read_data = shadow_store[idx];
                    end else if (hdr[SPILL_POS]) begin
                        rd_count = rd_count + CNT_W'(BUF_WORDS - pos);
                    end else begin
                        rd_count = rd_count + CNT_W'(slot_words(hdr[7:0]));
                    end
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic note_failure(input string what, input ring_response_t exp_r,
                                input ring_response_t got_r);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t %s: expected status %0d head_len %0d data %h, got status %0d head_len %0d data %h",
                     $realtime, what, exp_r.status, exp_r.head_len, exp_r.read_data,
                     got_r.status, got_r.head_len, got_r.read_data);
    endtask

    always @(posedge i_clk) begin : monitor
        ring_response_t got_r;
        ring_response_t exp_r;
        if (!i_rst_n) begin
            wr_count  = '0;
            rd_count  = '0;
            fill_addr = 0;
            fill_left = 0;
            written   = '0;
            pending_responses.delete();
        end else begin
            // Retire the result first: it always belongs to an older command.
            if (i_res_valid && i_res_ready) begin
                got_r.status    = t_status'(i_res_user);
                got_r.head_len  = i_res_data[7:0];
                got_r.read_data = i_res_data[39:8];
                if (pending_responses.size() == 0) begin
                    exp_r = '0;
                    note_failure("result with nothing outstanding", exp_r, got_r);
                end else begin
                    exp_r = pending_responses.pop_front();
                    if (got_r.status !== exp_r.status || got_r.head_len !== exp_r.head_len ||
                        got_r.read_data !== exp_r.read_data)
                        note_failure("result mismatch", exp_r, got_r);
                end
            end
            if (i_cmd_valid && i_cmd_ready)
                pending_responses.push_back(ring_response(i_cmd_user, i_cmd_data[7:0],
                                                          i_cmd_data[39:8], i_cmd_data[45:40]));
        end
        outstanding = pending_responses.size();
    end

endmodule

### verif/tb_top.sv
module tb_top
    import vprb_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int BUF_WORDS        = 1024;
    localparam int MAX_PACKET_WORDS = 64;
    localparam int FRAME_WORDS      = 4;
    localparam int STORE_DEPTH      = BUF_WORDS + MAX_PACKET_WORDS;
    localparam int TARGET_ITEMS     = 1650;
    localparam int QUIET_LIMIT      = 4000;

    // Actions the block takes and ignores
    localparam logic [2:0] ACT_SPARE_A = 3'd5;
    localparam logic [2:0] ACT_SPARE_B = 3'd6;
    localparam logic [2:0] ACT_SPARE_C = 3'd7;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    // byte_len [7:0], data_word [39:8], word_offset [45:40], zero pad [47:46]
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    // action [2:0]
    logic [2:0]             s_axis_tuser = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b1;
    // head_len [7:0], read_data [39:8]
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    // status [2:0]
    logic [2:0]             m_axis_tuser;

    int                     mismatches;
    int                     outstanding;
    logic                   ring_empty;
    int                     head_pos;
    logic [STORE_DEPTH-1:0] written;

    int send_idle_pct = 0;
    int stall_pct     = 0;
    int items_sent    = 0;
    int quiet_cycles  = 0;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    variable_packet_ring_buffer_unit #(
        .BUF_WORDS        (BUF_WORDS),
        .MAX_PACKET_WORDS (MAX_PACKET_WORDS),
        .FRAME_WORDS      (FRAME_WORDS)
    ) i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    vprb_ring_checker #(
        .BUF_WORDS        (BUF_WORDS),
        .MAX_PACKET_WORDS (MAX_PACKET_WORDS),
        .FRAME_WORDS      (FRAME_WORDS)
    ) i_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd_valid   (s_axis_tvalid),
        .i_cmd_ready   (s_axis_tready),
        .i_cmd_data    (s_axis_tdata),
        .i_cmd_user    (s_axis_tuser),
        .i_res_valid   (m_axis_tvalid),
        .i_res_ready   (m_axis_tready),
        .i_res_data    (m_axis_tdata),
        .i_res_user    (m_axis_tuser),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding),
        .o_ring_empty  (ring_empty),
        .o_head_pos    (head_pos),
        .o_written     (written)
    );

    // Receiver: stall at random, redrawn every cycle at the falling edge.
    always @(negedge i_clk) begin
        m_axis_tready <= (int'($urandom_range(99)) >= stall_pct);
    end

    // Watchdog: end the run when no transaction moves on either side for too long.
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    // Offer one command, idling first at random; return at the falling edge after
    // the transaction. valid gets one assignment per falling edge.
    task automatic send_cmd(input logic [2:0] act, input logic [7:0] len,
                            input logic [31:0] word, input logic [5:0] offs);
        if (int'($urandom_range(99)) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            do @(negedge i_clk); while (int'($urandom_range(99)) < send_idle_pct);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= act;
        s_axis_tdata  <= {2'b00, offs, word, len};
        do @(posedge i_clk); while (!s_axis_tready);
        @(negedge i_clk);
        items_sent++;
    endtask

    // Read a word of the head packet, steering the offset onto an entry that was
    // written since reset; fall back to a peek when none in reach is.
    task automatic read_head_word(input int unsigned want);
        int found;
        int o;
        found = -1;
        if (ring_empty) begin
            found = want % 64;
        end else begin
            for (int k = 0; k < 64; k++) begin
                o = (want + k) % 64;
                if (found < 0 && written[(head_pos + 1 + o) % STORE_DEPTH])
                    found = o;
            end
        end
        if (found >= 0)
            send_cmd(ACT_READ_WORD, 8'($urandom), $urandom, 6'(found));
        else
            send_cmd(ACT_PEEK, 8'($urandom), $urandom, 6'($urandom));
    endtask

    // Header followed by the slot's words; extra trims the fill (abandoned slot)
    // or runs past it (overrun).
    task automatic put_packet(input logic [7:0] len, input int extra);
        int n;
        send_cmd(ACT_PUT_HEADER, len, $urandom, 6'($urandom));
        n = int'(packet_words(len, 5'(FRAME_WORDS))) - 1 + extra;
        for (int k = 0; k < n; k++)
            send_cmd(ACT_PUT_WORD, 8'($urandom), $urandom, 6'($urandom));
    endtask

    initial begin : stimulus
        int          pick;
        int          extra;
        int          words;
        logic [7:0]  len;
        logic [2:0]  act;
        bit          produce_heavy;

        // Hold reset from the start, release it at a falling edge.
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Empty ring: every head access must report empty.
        send_cmd(ACT_PEEK, 8'hFF, 32'hFFFF_FFFF, 6'h3F);
        read_head_word(63);
        send_cmd(ACT_RELEASE, 8'h00, 32'h0, 6'h00);
        // No slot reserved yet.
        send_cmd(ACT_PUT_WORD, 8'h00, 32'h1234_5678, 6'h00);
        // Too long: largest length, and one past the largest that fits.
        send_cmd(ACT_PUT_HEADER, 8'd255, 32'h0, 6'h00);
        send_cmd(ACT_PUT_HEADER, 8'd237, 32'h0, 6'h00);
        // Reserved actions do nothing.
        send_cmd(ACT_SPARE_A, 8'hA5, 32'hDEAD_BEEF, 6'h2A);
        send_cmd(ACT_SPARE_B, 8'h5A, 32'h0, 6'h15);
        send_cmd(ACT_SPARE_C, 8'hFF, 32'hFFFF_FFFF, 6'h3F);
        // Zero-length packet: header plus frame words only.
        send_cmd(ACT_PUT_HEADER, 8'd0, 32'h0, 6'h00);
        send_cmd(ACT_PUT_WORD, 8'h00, 32'h0000_0000, 6'h00);
        send_cmd(ACT_PUT_WORD, 8'hFF, 32'hFFFF_FFFF, 6'h3F);
        send_cmd(ACT_PUT_WORD, 8'h00, 32'h5555_5555, 6'h00);
        send_cmd(ACT_PUT_WORD, 8'h00, 32'hAAAA_AAAA, 6'h00);
        // Slot is complete: one more word overruns it.
        send_cmd(ACT_PUT_WORD, 8'h00, 32'hFFFF_FFFF, 6'h00);
        send_cmd(ACT_PEEK, 8'h00, 32'h0, 6'h00);
        read_head_word(3);
        // Largest packet, filled only partly, then abandoned by a new header.
        put_packet(8'd236, -61);
        put_packet(8'd1, -4);
        // Drain the three packets, peeking between releases.
        send_cmd(ACT_RELEASE, 8'h00, 32'h0, 6'h00);
        send_cmd(ACT_PEEK, 8'h00, 32'h0, 6'h00);
        send_cmd(ACT_RELEASE, 8'h00, 32'h0, 6'h00);
        send_cmd(ACT_PEEK, 8'h00, 32'h0, 6'h00);
        send_cmd(ACT_RELEASE, 8'h00, 32'h0, 6'h00);

        // Random traffic in four idling phases; alternate between filling the
        // ring toward full (and across its end) and draining it.
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 76; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 76; end
                default: begin send_idle_pct = 31; stall_pct = 31; end
            endcase
            // Hold off once until every outstanding result has drained; drop
            // valid first so the last command is not offered again.
            if (phase == 2) begin
                s_axis_tvalid <= 1'b0;
                do @(negedge i_clk); while (outstanding != 0);
            end
            while (items_sent < TARGET_ITEMS * (phase + 1) / 4) begin
                produce_heavy = ((items_sent / 120) % 2) == 0;
                pick = $urandom_range(99);
                if (pick < (produce_heavy ? 60 : 25)) begin
                    case ($urandom_range(9))
                        0: len = 8'd0;
                        1: len = 8'd236;
                        2: len = 8'($urandom_range(255, 237));
                        default: len = 8'($urandom_range(236, 0));
                    endcase
                    words = int'(packet_words(len, 5'(FRAME_WORDS))) - 1;
                    case ($urandom_range(9))
                        0: extra = 0 - int'($urandom_range(words, 1));
                        1: extra = int'($urandom_range(2, 1));
                        default: extra = 0;
                    endcase
                    put_packet(len, extra);
                end else if (pick < 85) begin
                    send_cmd(ACT_PEEK, 8'($urandom), $urandom, 6'($urandom));
                    repeat ($urandom_range(3, 0)) read_head_word($urandom_range(63));
                    if ($urandom_range(9) != 0)
                        send_cmd(ACT_RELEASE, 8'($urandom), $urandom, 6'($urandom));
                end else begin
                    act = 3'($urandom_range(7));
                    if (act == ACT_READ_WORD)
                        read_head_word($urandom_range(63));
                    else
                        send_cmd(act, 8'($urandom), $urandom, 6'($urandom));
                end
            end
        end

        // Drop valid, wait out the remaining results and the pipeline tail.
        s_axis_tvalid <= 1'b0;
        while (outstanding != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
